@@ rtl/core/prrts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prrts_pkg - shared types and codes of the task scheduler
// Field widths, request and status codes, controller/datapath command types.
// ----------------------------------------------------------------------------
package prrts_pkg;

	localparam int REQ_W      = 3;
	localparam int PRIO_W     = 3;
	localparam int DEV_W      = 8;
	localparam int STAT_W     = 3;
	localparam int TID_W      = 6;
	localparam int WOKE_W     = 7;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int QUANT_W    = 16;
	localparam int DCNT_W     = 9;

	localparam logic [REQ_W-1:0] REQ_START  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_EXEC   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_FORK   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_WAIT   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SIGNAL = 3'd4;
	localparam logic [REQ_W-1:0] REQ_EXIT   = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_DEV  = 3'd1;
	localparam logic [STAT_W-1:0] ST_BAD_PRIO = 3'd2;
	localparam logic [STAT_W-1:0] ST_NO_SLOT  = 3'd3;
	localparam logic [STAT_W-1:0] ST_BAD_STATE = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICES = 1'b1;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CAPTURE,
		CMD_START,
		CMD_FORK,
		CMD_WAIT_WR,
		CMD_EXIT,
		CMD_SIG_LOAD,
		CMD_SIG_RDT,
		CMD_SIG_MOVE,
		CMD_SIG_END,
		CMD_STEP_EVAL,
		CMD_STEP_POP,
		CMD_STEP_SWAP,
		CMD_RESULT
	} cmd_t;

	typedef struct packed {
		cmd_t              op;
		logic [STAT_W-1:0] status;
	} dp_cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             started;
		logic             start_bad;
		logic             prio_bad;
		logic             full;
		logic             dev_bad;
		logic             replace;
		logic             sig_more;
	} dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/prrts_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prrts_if - channel interfaces of the task scheduler
// Request, result and configuration write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface prrts_req_if import prrts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [PRIO_W-1:0] task_priority;
	logic [DEV_W-1:0]  device_index;
	modport source (output valid, req_type, task_priority, device_index, input ready);
	modport sink   (input valid, req_type, task_priority, device_index, output ready);
endinterface

interface prrts_res_if import prrts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [TID_W-1:0]  running_task;
	logic              running_valid;
	logic [TID_W-1:0]  new_task;
	logic [WOKE_W-1:0] woken_count;
	logic              all_idle;
	modport source (output valid, status, running_task, running_valid, new_task,
		woken_count, all_idle, input ready);
	modport sink   (input valid, status, running_task, running_valid, new_task,
		woken_count, all_idle, output ready);
endinterface

interface prrts_cfg_if import prrts_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/prrts_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prrts_ctrl - scheduler sequencer
// Decodes the captured request, walks it through the datapath steps.
// ----------------------------------------------------------------------------
module prrts_ctrl import prrts_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_WAIT_WR, S_SIG_LOAD, S_SIG_CHK, S_SIG_DO,
		S_STEP_A, S_STEP_B, S_STEP_C, S_DONE
	} state_t;

	state_t            state_q, state_d;
	logic [STAT_W-1:0] status_q, status_d;
	logic              out_valid_q;
	logic              load_res;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign load_res  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d    = state_q;
		status_d   = status_q;
		cmd.op     = CMD_NONE;
		cmd.status = status_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = CMD_CAPTURE;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				status_d = ST_OK;
				state_d  = S_DONE;
				if (stat.req > REQ_EXIT) begin
					status_d = ST_OK;
				end else if (stat.req == REQ_START) begin
					if (stat.started) begin
						status_d = ST_BAD_STATE;
					end else if (stat.start_bad) begin
						status_d = ST_BAD_DEV;
					end else begin
						cmd.op  = CMD_START;
						state_d = S_STEP_A;
					end
				end else if (!stat.started) begin
					status_d = ST_BAD_STATE;
				end else if (stat.req == REQ_EXEC) begin
					state_d = S_STEP_A;
				end else if (stat.req == REQ_FORK) begin
					if (stat.prio_bad) begin
						status_d = ST_BAD_PRIO;
					end else if (stat.full) begin
						status_d = ST_NO_SLOT;
					end else begin
						cmd.op  = CMD_FORK;
						state_d = S_STEP_A;
					end
				end else if (stat.req == REQ_WAIT || stat.req == REQ_SIGNAL) begin
					if (stat.dev_bad) begin
						status_d = ST_BAD_DEV;
					end else if (stat.req == REQ_WAIT) begin
						state_d = S_WAIT_WR;
					end else begin
						state_d = S_SIG_LOAD;
					end
				end else begin
					cmd.op  = CMD_EXIT;
					state_d = S_STEP_A;
				end
			end
			S_WAIT_WR: begin
				cmd.op  = CMD_WAIT_WR;
				state_d = S_STEP_A;
			end
			S_SIG_LOAD: begin
				cmd.op  = CMD_SIG_LOAD;
				state_d = S_SIG_CHK;
			end
			S_SIG_CHK: begin
				if (stat.sig_more) begin
					cmd.op  = CMD_SIG_RDT;
					state_d = S_SIG_DO;
				end else begin
					cmd.op  = CMD_SIG_END;
					state_d = S_STEP_A;
				end
			end
			S_SIG_DO: begin
				cmd.op  = CMD_SIG_MOVE;
				state_d = S_SIG_CHK;
			end
			S_STEP_A: begin
				cmd.op  = CMD_STEP_EVAL;
				state_d = stat.replace ? S_STEP_B : S_DONE;
			end
			S_STEP_B: begin
				cmd.op  = CMD_STEP_POP;
				state_d = S_STEP_C;
			end
			S_STEP_C: begin
				cmd.op  = CMD_STEP_SWAP;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (load_res) begin
					cmd.op  = CMD_RESULT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/prrts_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prrts_dp - scheduler datapath
// Task table, ready and wait queues, running task, quantum, result register.
// ----------------------------------------------------------------------------
module prrts_dp import prrts_pkg::*; #(
	parameter int LEVELS    = 6,
	parameter int DEVICES   = 256,
	parameter int MAX_TASKS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [REQ_W-1:0]      in_req,
	input  wire logic [PRIO_W-1:0]     in_prio,
	input  wire logic [DEV_W-1:0]      in_dev,
	input  wire dp_cmd_t               cmd,
	output dp_stat_t                   stat,
	output logic [STAT_W-1:0]          res_status,
	output logic [TID_W-1:0]           res_running,
	output logic                       res_running_valid,
	output logic [TID_W-1:0]           res_new,
	output logic [WOKE_W-1:0]          res_woken,
	output logic                       res_idle
);

	localparam int IDW = $clog2(MAX_TASKS);
	localparam int LVW = $clog2(LEVELS);
	localparam int DVW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
	localparam int TMW = $clog2(MAX_TASKS + 1);

	// configuration
	logic [QUANT_W-1:0] tq_q;
	logic [DCNT_W-1:0]  dc_q;

	// captured request
	logic [REQ_W-1:0]  req_q;
	logic [PRIO_W-1:0] prio_q;
	logic [DEV_W-1:0]  dev_q;

	// scheduler state
	logic               started_q;
	logic [IDW-1:0]     cur_q;
	logic               cur_vld_q;
	logic [LVW-1:0]     cur_lvl_q;
	logic [QUANT_W-1:0] quant_q;
	logic [TMW-1:0]     made_q;
	logic [IDW-1:0]     new_id_q;
	logic [TMW-1:0]     woken_q;
	logic [LVW-1:0]     best_q;
	logic [IDW-1:0]     next_q;
	logic [LVW-1:0]     next_lvl_q;
	logic [IDW-1:0]     sig_head_q;
	logic [IDW-1:0]     sig_tail_q;
	logic               sig_live_q;

	logic [IDW-1:0]     rhead_q [LEVELS];
	logic [IDW-1:0]     rtail_q [LEVELS];
	logic [LEVELS-1:0]  rne_q;
	logic [DEVICES-1:0] wne_q;

	// memories
	logic [LVW-1:0]     lvl_mem  [MAX_TASKS];
	logic [IDW-1:0]     link_mem [MAX_TASKS];
	logic [2*IDW-1:0]   wq_mem   [DEVICES];
	logic [LVW-1:0]     lvl_rd;
	logic [IDW-1:0]     link_rd;
	logic [2*IDW-1:0]   wq_rd;

	logic [QUANT_W-1:0] qload, qdec;
	logic               expired;
	logic [LVW-1:0]     best_w;
	logic               any_rdy;
	logic               replace_w;
	logic [DCNT_W-1:0]  dev_lim;
	logic [DVW-1:0]     dix;
	logic               wne_cur;
	logic [IDW-1:0]     wq_head, wq_tail;
	logic [IDW-1:0]     t_raddr;

	logic               app_en;
	logic [LVW-1:0]     app_lvl;
	logic [IDW-1:0]     app_id;
	logic               lw_en;
	logic [IDW-1:0]     lw_addr, lw_data;
	logic               vw_en;
	logic [IDW-1:0]     vw_addr;
	logic [LVW-1:0]     vw_data;
	logic               wq_we;

	assign qload   = (tq_q == '0) ? QUANT_W'(1) : tq_q;
	assign qdec    = (quant_q != '0) ? quant_q - QUANT_W'(1) : '0;
	assign expired = (qdec == '0);
	assign dev_lim = (dc_q > DCNT_W'(DEVICES)) ? DCNT_W'(DEVICES) : dc_q;
	assign dix     = dev_q[DVW-1:0];
	assign wne_cur = wne_q[dix];
	assign wq_head = wq_rd[2*IDW-1:IDW];
	assign wq_tail = wq_rd[IDW-1:0];
	assign any_rdy = |rne_q;

	always_comb begin
		best_w = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (rne_q[i]) begin
				best_w = LVW'(i);
			end
		end
	end

	assign replace_w = any_rdy && (!cur_vld_q || (best_w > cur_lvl_q) ||
		((best_w == cur_lvl_q) && expired));

	assign stat.req       = req_q;
	assign stat.started   = started_q;
	assign stat.start_bad = dc_q > DCNT_W'(DEVICES);
	assign stat.prio_bad  = 4'(prio_q) >= 4'(LEVELS);
	assign stat.full      = made_q >= TMW'(MAX_TASKS);
	assign stat.dev_bad   = {1'b0, dev_q} >= dev_lim;
	assign stat.replace   = replace_w;
	assign stat.sig_more  = sig_live_q && (woken_q < TMW'(MAX_TASKS));

	// ready-queue append source
	always_comb begin
		app_en  = 1'b0;
		app_lvl = cur_lvl_q;
		app_id  = cur_q;
		case (cmd.op)
			CMD_FORK: begin
				app_en  = 1'b1;
				app_lvl = prio_q[LVW-1:0];
				app_id  = made_q[IDW-1:0];
			end
			CMD_SIG_MOVE: begin
				app_en  = 1'b1;
				app_lvl = lvl_rd;
				app_id  = sig_head_q;
			end
			CMD_STEP_SWAP: begin
				app_en  = cur_vld_q;
			end
			default: begin
				app_en  = 1'b0;
			end
		endcase
	end

	// link and level table writes
	always_comb begin
		lw_en   = 1'b0;
		lw_addr = rtail_q[app_lvl];
		lw_data = app_id;
		if (app_en && rne_q[app_lvl]) begin
			lw_en = 1'b1;
		end else if (cmd.op == CMD_WAIT_WR && cur_vld_q && wne_cur) begin
			lw_en   = 1'b1;
			lw_addr = wq_tail;
			lw_data = cur_q;
		end
		vw_en   = (cmd.op == CMD_START) || (cmd.op == CMD_FORK);
		vw_addr = (cmd.op == CMD_FORK) ? made_q[IDW-1:0] : '0;
		vw_data = (cmd.op == CMD_FORK) ? prio_q[LVW-1:0] : '0;
	end

	assign wq_we   = (cmd.op == CMD_WAIT_WR) && cur_vld_q;
	assign t_raddr = (cmd.op == CMD_SIG_RDT) ? sig_head_q : rhead_q[best_w];

	always_ff @(posedge clk) begin
		if (lw_en) begin
			link_mem[lw_addr] <= lw_data;
		end
		if (vw_en) begin
			lvl_mem[vw_addr] <= vw_data;
		end
		lvl_rd  <= lvl_mem[t_raddr];
		link_rd <= link_mem[t_raddr];
	end

	always_ff @(posedge clk) begin
		if (wq_we) begin
			wq_mem[dix] <= {(wne_cur ? wq_head : cur_q), cur_q};
		end
		wq_rd <= wq_mem[dix];
	end

	// captured request and result register
	always_ff @(posedge clk) begin
		if (cmd.op == CMD_CAPTURE) begin
			req_q  <= in_req;
			prio_q <= in_prio;
			dev_q  <= in_dev;
		end
		if (cmd.op == CMD_RESULT) begin
			res_status        <= cmd.status;
			res_running       <= cur_vld_q ? TID_W'(cur_q) : '0;
			res_running_valid <= cur_vld_q;
			res_new           <= TID_W'(new_id_q);
			res_woken         <= WOKE_W'(woken_q);
			res_idle          <= !cur_vld_q && !any_rdy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tq_q <= QUANT_W'(1);
			dc_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_QUANTUM: tq_q <= cfg_data;
				CFG_DEVICES: dc_q <= cfg_data[DCNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ready queues
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rne_q <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				rhead_q[i] <= '0;
				rtail_q[i] <= '0;
			end
		end else if (cmd.op == CMD_START) begin
			rne_q <= '0;
		end else if (cmd.op == CMD_STEP_POP) begin
			if (rhead_q[best_q] == rtail_q[best_q]) begin
				rne_q[best_q] <= 1'b0;
			end else begin
				rhead_q[best_q] <= link_rd;
			end
		end else if (app_en) begin
			if (!rne_q[app_lvl]) begin
				rhead_q[app_lvl] <= app_id;
			end
			rtail_q[app_lvl] <= app_id;
			rne_q[app_lvl]   <= 1'b1;
		end
	end

	// wait-queue occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wne_q <= '0;
		end else if (cmd.op == CMD_START) begin
			wne_q <= '0;
		end else if (wq_we) begin
			wne_q[dix] <= 1'b1;
		end else if (cmd.op == CMD_SIG_END) begin
			wne_q[dix] <= 1'b0;
		end
	end

	// running task, quantum, signal walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= 1'b0;
			cur_q      <= '0;
			cur_vld_q  <= 1'b0;
			cur_lvl_q  <= '0;
			quant_q    <= '0;
			made_q     <= '0;
			new_id_q   <= '0;
			woken_q    <= '0;
			best_q     <= '0;
			next_q     <= '0;
			next_lvl_q <= '0;
			sig_head_q <= '0;
			sig_tail_q <= '0;
			sig_live_q <= 1'b0;
		end else begin
			case (cmd.op)
				CMD_CAPTURE: begin
					new_id_q <= '0;
					woken_q  <= '0;
				end
				CMD_START: begin
					made_q    <= TMW'(1);
					cur_q     <= '0;
					cur_vld_q <= 1'b1;
					cur_lvl_q <= '0;
					quant_q   <= qload;
					started_q <= 1'b1;
				end
				CMD_FORK: begin
					made_q   <= made_q + TMW'(1);
					new_id_q <= made_q[IDW-1:0];
				end
				CMD_WAIT_WR, CMD_EXIT: begin
					cur_vld_q <= 1'b0;
					cur_q     <= '0;
				end
				CMD_SIG_LOAD: begin
					sig_head_q <= wq_head;
					sig_tail_q <= wq_tail;
					sig_live_q <= wne_cur;
				end
				CMD_SIG_MOVE: begin
					woken_q <= woken_q + TMW'(1);
					if (sig_head_q == sig_tail_q) begin
						sig_live_q <= 1'b0;
					end else begin
						sig_head_q <= link_rd;
					end
				end
				CMD_SIG_END: begin
					sig_live_q <= 1'b0;
				end
				CMD_STEP_EVAL: begin
					best_q <= best_w;
					if (!replace_w) begin
						if (cur_vld_q) begin
							quant_q <= expired ? qload : qdec;
						end else begin
							quant_q <= '0;
						end
					end
				end
				CMD_STEP_POP: begin
					next_q     <= rhead_q[best_q];
					next_lvl_q <= lvl_rd;
				end
				CMD_STEP_SWAP: begin
					cur_q     <= next_q;
					cur_vld_q <= 1'b1;
					cur_lvl_q <= next_lvl_q;
					quant_q   <= qload;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/priority_round_robin_task_scheduler_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// priority_round_robin_task_scheduler_top - preemptive priority scheduler
// Ready queue per level, wait queue per device, round-robin on the quantum.
// ----------------------------------------------------------------------------
// Usage:
//   req : request items (req_type, task_priority, device_index). One item is
//         taken at a time; ready is high only while the sequencer is idle.
//   res : one result item per request, held in an output register until
//         taken. The next request is accepted while a result still waits;
//         its own result is held back until the previous one has gone.
//   cfg : register writes (index 0 quantum length, 1 device_count), always
//         ready; the user writes only while no request is in flight, which
//         the block itself does not enforce.
// Sequence from accept to result valid: rejected or unknown requests go
//   straight to the result; others evaluate the step and, when a ready task
//   takes over, pop it and swap it in. A wait first writes the wait queue;
//   a signal loads it, then does a task-table read and an append per waiter.
// Reset clears all queues and the running task; nothing runs until start.
// A stalled receiver holds the result and, at most, one request behind it.
// ----------------------------------------------------------------------------
module priority_round_robin_task_scheduler_top import prrts_pkg::*; #(
	parameter int LEVELS    = 6,
	parameter int DEVICES   = 256,
	parameter int MAX_TASKS = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	prrts_req_if.sink  req,
	prrts_res_if.source res,
	prrts_cfg_if.sink  cfg
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// configuration is always taken
	assign cfg.ready = 1'b1;

	prrts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	prrts_dp #(
		.LEVELS    (LEVELS),
		.DEVICES   (DEVICES),
		.MAX_TASKS (MAX_TASKS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg.valid),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.in_req            (req.req_type),
		.in_prio           (req.task_priority),
		.in_dev            (req.device_index),
		.cmd               (cmd),
		.stat              (stat),
		.res_status        (res.status),
		.res_running       (res.running_task),
		.res_running_valid (res.running_valid),
		.res_new           (res.new_task),
		.res_woken         (res.woken_count),
		.res_idle          (res.all_idle)
	);

`ifndef SYNTHESIS
	// no running task reports as task zero
	a_run_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.running_valid |-> res.running_task == '0)
		else $error("running_task nonzero with no running task");

	// idle means nothing runs
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.all_idle |-> !res.running_valid)
		else $error("all_idle with a running task");

	// a rejected request forks and wakes nothing
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status != ST_OK |-> res.new_task == '0 && res.woken_count == '0)
		else $error("rejected request reports a side effect");
`endif

endmodule
`default_nettype wire
